// File: rtl/core/token_scanner_classifier_unit_assert.svh
// ----------------------------------------------------------------------------
// Token scanner assertion macros
// Concurrent checks, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef TOKEN_SCANNER_CLASSIFIER_UNIT_ASSERT_SVH
`define TOKEN_SCANNER_CLASSIFIER_UNIT_ASSERT_SVH

`ifndef SYNTH
`define TSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TSC_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define TSC_ASSERT(lbl, prop, msg)
`define TSC_NEVER(lbl, expr, msg)
`endif

`endif

// File: rtl/core/tsc_pkg.sv
// ----------------------------------------------------------------------------
// Token scanner package
// Shared widths, codes and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsc_pkg;

	localparam int LINE_BITS  = 20;
	localparam int COL_BITS   = 16;
	localparam int CNT_BITS   = 16;
	localparam int VAL_BITS   = 31;
	localparam int ADDR_BITS  = 3;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
	localparam int FCNT_BITS  = $clog2(FIFO_DEPTH + 1);

	localparam logic KIND_TOKEN = 1'b0;
	localparam logic KIND_END   = 1'b1;

	localparam logic [1:0] SYM_VALID     = 2'd0;
	localparam logic [1:0] SYM_BAD_CHARS = 2'd1;
	localparam logic [1:0] SYM_TOO_LONG  = 2'd2;

	localparam logic [0:0] REG_MAX_SYM_LEN = 1'b0;
	localparam logic [7:0] MAX_SYM_RESET   = 8'd16;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;

	typedef struct packed {
		logic                 kind;
		logic [LINE_BITS-1:0] line_number;
		logic [COL_BITS-1:0]  column;
		logic [CNT_BITS-1:0]  token_length;
		logic                 is_number;
		logic [VAL_BITS-1:0]  number_value;
		logic [1:0]           symbol_status;
		logic                 address_ok;
		logic [7:0]           first_char;
		logic                 last;
	} res_t;

	// results of one step: r1 only ever follows r0
	typedef struct packed {
		logic v0;
		logic v1;
		res_t r0;
		res_t r1;
	} push_t;

	typedef struct packed {
		logic                 room;
		logic [FCNT_BITS-1:0] count;
	} fifo_stat_t;

endpackage

// File: rtl/core/tsc_lexer.sv
// ----------------------------------------------------------------------------
// Token scanner lexer
// Stream state and per-byte classification; emits up to two results a step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsc_lexer import tsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  character,
	input  logic        end_of_input,
	input  logic [7:0]  max_sym_len,
	output push_t       push
);

	localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
	localparam logic [COL_BITS-1:0]  COL_MAX  = '1;
	localparam logic [CNT_BITS-1:0]  CNT_MAX  = '1;
	localparam logic [VAL_BITS-1:0]  VAL_MAX  = '1;

	logic [LINE_BITS-1:0] line_count_q, lc_n;
	logic [COL_BITS-1:0]  line_length_q, ll_cur;
	logic                 at_ls_q, in_tok_q;
	logic [COL_BITS-1:0]  tok_start_q, start_e;
	logic [CNT_BITS-1:0]  tok_cnt_q, cnt_e;
	logic                 all_dig_q, all_dig_e, sym_ok_q, sym_ok_e;
	logic [7:0]           first_q, first_e;
	logic [VAL_BITS-1:0]  acc_q, acc_e, acc_n;
	logic                 ws, is_dig, is_let, dig_run;
	logic [VAL_BITS+3:0]  prod;
	res_t                 tok_r, end_r;
	logic                 addr;
	logic [1:0]           status;

	always_comb begin
		ws     = (character == CH_SPACE) || (character == CH_TAB) || (character == CH_LF);
		is_dig = (character >= "0") && (character <= "9");
		is_let = ((character >= "a") && (character <= "z")) ||
		         ((character >= "A") && (character <= "Z"));
		lc_n   = line_count_q;
		if (at_ls_q && line_count_q != LINE_MAX) begin
			lc_n = line_count_q + 1'b1;
		end
		ll_cur = at_ls_q ? '0 : line_length_q;

		// a fresh token starts from clean flags
		start_e   = in_tok_q ? tok_start_q : ((ll_cur != COL_MAX) ? ll_cur + 1'b1 : COL_MAX);
		cnt_e     = in_tok_q ? tok_cnt_q : '0;
		all_dig_e = in_tok_q ? all_dig_q : 1'b1;
		sym_ok_e  = in_tok_q ? sym_ok_q : 1'b1;
		first_e   = in_tok_q ? first_q : character;
		acc_e     = in_tok_q ? acc_q : '0;

		dig_run = all_dig_e && is_dig;
		prod    = ({4'b0, acc_e} << 3) + ({4'b0, acc_e} << 1) +
		          (VAL_BITS+4)'(character - 8'h30);
		acc_n   = '0;
		if (dig_run) begin
			acc_n = (prod > {4'b0, VAL_MAX}) ? VAL_MAX : prod[VAL_BITS-1:0];
		end

		status = sym_ok_q ? SYM_VALID : SYM_BAD_CHARS;
		if (tok_cnt_q > {8'b0, max_sym_len}) begin
			status = SYM_TOO_LONG;
		end
		addr = (tok_cnt_q == CNT_BITS'(1)) && ((first_q == "A") || (first_q == "I") ||
		       (first_q == "R") || (first_q == "E"));

		tok_r.kind          = KIND_TOKEN;
		tok_r.line_number   = end_of_input ? line_count_q : lc_n;
		tok_r.column        = tok_start_q;
		tok_r.token_length  = tok_cnt_q;
		tok_r.is_number     = all_dig_q;
		tok_r.number_value  = all_dig_q ? acc_q : '0;
		tok_r.symbol_status = status;
		tok_r.address_ok    = addr;
		tok_r.first_char    = first_q;
		tok_r.last          = !end_of_input;

		end_r               = '0;
		end_r.kind          = KIND_END;
		end_r.line_number   = line_count_q;
		end_r.column        = line_length_q;
		end_r.last          = 1'b1;

		push = '0;
		if (step) begin
			if (end_of_input) begin
				push.v0 = 1'b1;
				push.v1 = in_tok_q;
				push.r0 = in_tok_q ? tok_r : end_r;
				push.r1 = end_r;
			end else if (ws && in_tok_q) begin
				push.v0 = 1'b1;
				push.r0 = tok_r;
				push.r1 = end_r;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q  <= '0;
			line_length_q <= '0;
			at_ls_q       <= 1'b1;
			in_tok_q      <= 1'b0;
			tok_start_q   <= '0;
			tok_cnt_q     <= '0;
			all_dig_q     <= 1'b1;
			sym_ok_q      <= 1'b1;
			first_q       <= '0;
			acc_q         <= '0;
		end else if (step) begin
			if (end_of_input) begin
				line_count_q  <= '0;
				line_length_q <= '0;
				at_ls_q       <= 1'b1;
				in_tok_q      <= 1'b0;
				tok_start_q   <= '0;
				tok_cnt_q     <= '0;
				all_dig_q     <= 1'b1;
				sym_ok_q      <= 1'b1;
				first_q       <= '0;
				acc_q         <= '0;
			end else begin
				line_count_q  <= lc_n;
				line_length_q <= (ll_cur != COL_MAX) ? ll_cur + 1'b1 : COL_MAX;
				at_ls_q       <= (character == CH_LF);
				if (ws) begin
					in_tok_q <= 1'b0;
				end else begin
					in_tok_q    <= 1'b1;
					tok_start_q <= start_e;
					tok_cnt_q   <= (cnt_e != CNT_MAX) ? cnt_e + 1'b1 : CNT_MAX;
					all_dig_q   <= dig_run;
					acc_q       <= acc_n;
					first_q     <= first_e;
					sym_ok_q    <= sym_ok_e && (is_let || (is_dig && cnt_e != '0));
				end
			end
		end
	end

endmodule

// File: rtl/core/tsc_result_fifo.sv
// ----------------------------------------------------------------------------
// Token scanner result queue
// Four-entry queue, takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsc_result_fifo import tsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  push_t      push,
	input  logic       pop,
	output logic       out_valid,
	output res_t       out_res,
	output fifo_stat_t stat
);

	res_t                 mem_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0]  wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [FCNT_BITS-1:0] count_q;
	logic                 do_pop;
	logic [1:0]           n_push;

	assign wr_ptr_p1  = wr_ptr_q + 1'b1;
	assign out_valid  = (count_q != '0);
	assign out_res    = mem_q[rd_ptr_q];
	assign do_pop     = pop && out_valid;
	assign n_push     = {1'b0, push.v0} + {1'b0, push.v1};
	assign stat.count = count_q;
	assign stat.room  = (count_q <= FCNT_BITS'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wr_ptr_p1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_BITS'(n_push);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + FCNT_BITS'(n_push) - FCNT_BITS'(do_pop);
		end
	end

endmodule

// File: rtl/core/token_scanner_classifier_unit.sv
// ----------------------------------------------------------------------------
// Token scanner / classifier, top level
// Flow: a byte is registered, then its results are written into the output queue
// once there is room for them; a token shows on m_tdata when it heads the queue.
// Throughput: one byte per cycle, held only by the four-entry result queue.
// Reset: arst_n clears all stream state; max symbol length returns to 16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "token_scanner_classifier_unit_assert.svh"

module token_scanner_classifier_unit import tsc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// APB config
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// byte stream in
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,  // character
	input  logic                 s_tuser,  // end_of_input
	// result stream out
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// line_number[19:0], column[35:20], token_length[51:36], is_number[52],
	// number_value[83:53], symbol_status[85:84], address_ok[86],
	// first_char[94:87], zero pad[95]
	output logic [95:0]          m_tdata,
	output logic                 m_tuser,  // kind
	output logic                 m_tlast
);

	logic       valid_s1, eoi_s1, adv;
	logic [7:0] char_s1;
	logic [7:0] max_sym_q;
	logic       reg_sel;
	push_t      push;
	fifo_stat_t fstat;
	res_t       ores;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[ADDR_BITS-1] == REG_MAX_SYM_LEN);
	assign prdata  = reg_sel ? {24'b0, max_sym_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_sym_q <= MAX_SYM_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			max_sym_q <= pwdata[7:0];
		end
	end

	// input word register
	assign adv      = valid_s1 && fstat.room;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			eoi_s1  <= s_tuser;
		end
	end

	tsc_lexer u_lexer (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv),
		.character    (char_s1),
		.end_of_input (eoi_s1),
		.max_sym_len  (max_sym_q),
		.push         (push)
	);

	tsc_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (m_tready),
		.out_valid (m_tvalid),
		.out_res   (ores),
		.stat      (fstat)
	);

	assign m_tuser = ores.kind;
	assign m_tlast = ores.last;
	assign m_tdata = {1'b0, ores.first_char, ores.address_ok, ores.symbol_status,
	                  ores.number_value, ores.is_number, ores.token_length,
	                  ores.column, ores.line_number};

	`TSC_NEVER(a_fifo_bound, fstat.count > FCNT_BITS'(FIFO_DEPTH), "result queue overrun")
	`TSC_ASSERT(a_push_room, (push.v0 |-> fstat.room), "push without queue room")
	`TSC_ASSERT(a_pair_end, (push.v1 |-> (push.v0 && push.r1.kind == KIND_END)), "bad pair")
	`TSC_ASSERT(a_end_last, ((m_tvalid && m_tuser == KIND_END) |-> m_tlast), "end not last")

endmodule

// File: bench/token_record_checker.sv
// ----------------------------------------------------------------------------
// Token record checker
// Watches the byte stream, the result stream and the register port. It tracks
// the scanner state itself, queues the records each accepted byte must
// produce, and compares every accepted result word with the oldest record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module token_record_checker import tsc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	input  logic                 pready,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [7:0]           s_tdata,  // character
	input  logic                 s_tuser,  // end_of_input
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	// line_number, column, token_length, is_number, number_value,
	// symbol_status, address_ok, first_char, zero pad
	input  logic [95:0]          m_tdata,
	input  logic                 m_tuser,  // kind
	input  logic                 m_tlast,
	output int                   records_pending,
	output int                   error_count
);

	localparam logic [ADDR_BITS-1:0] MAX_SYM_LEN_ADDR = ADDR_BITS'(4 * REG_MAX_SYM_LEN);

	// scanner state as the block should hold it
	logic [7:0]          sym_limit;
	logic [LINE_BITS-1:0] n_lines;
	logic [COL_BITS-1:0] cur_len;
	logic                bol;
	logic                tok_open;
	logic [COL_BITS-1:0] tok_col;
	logic [CNT_BITS-1:0] tok_len;
	logic                digits_only;
	logic                sym_ok;
	logic [7:0]          tok_first;
	logic [VAL_BITS-1:0] tok_value;

	res_t expected_tokens[$];
	res_t want_rec;
	res_t got_rec;

	initial error_count = 0;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic res_t token_record(input logic is_last);
		res_t r;
		r = '0;
		r.kind         = KIND_TOKEN;
		r.line_number  = n_lines;
		r.column       = tok_col;
		r.token_length = tok_len;
		r.is_number    = digits_only;
		r.number_value = digits_only ? tok_value : '0;
		// length test wins over the character test
		if (tok_len > CNT_BITS'(sym_limit))
			r.symbol_status = SYM_TOO_LONG;
		else if (!sym_ok)
			r.symbol_status = SYM_BAD_CHARS;
		else
			r.symbol_status = SYM_VALID;
		r.address_ok = (tok_len == 1) && (tok_first == "A" || tok_first == "I" ||
			tok_first == "R" || tok_first == "E");
		r.first_char = tok_first;
		r.last       = is_last;
		return r;
	endfunction

	task automatic clear_stream();
		n_lines     = '0;
		cur_len     = '0;
		bol         = 1'b1;
		tok_open    = 1'b0;
		tok_col     = '0;
		tok_len     = '0;
		digits_only = 1'b1;
		sym_ok      = 1'b1;
		tok_first   = '0;
		tok_value   = '0;
	endtask

	task automatic scan_byte(input logic [7:0] ch, input logic eoi);
		res_t        end_rec;
		logic [63:0] wide;
		if (eoi) begin
			if (tok_open)
				expected_tokens.push_back(token_record(1'b0));
			end_rec             = '0;
			end_rec.kind        = KIND_END;
			end_rec.line_number = n_lines;
			end_rec.column      = cur_len;
			end_rec.last        = 1'b1;
			expected_tokens.push_back(end_rec);
			clear_stream();
			return;
		end
		if (bol) begin
			if (n_lines != '1)
				n_lines++;
			cur_len = '0;
			bol     = 1'b0;
		end
		if (ch == CH_SPACE || ch == CH_TAB || ch == CH_LF) begin
			if (tok_open) begin
				expected_tokens.push_back(token_record(1'b1));
				tok_open = 1'b0;
			end
		end else begin
			if (!tok_open) begin
				tok_open    = 1'b1;
				tok_col     = (cur_len != '1) ? cur_len + 1'b1 : cur_len;
				tok_len     = '0;
				digits_only = 1'b1;
				sym_ok      = 1'b1;
				tok_first   = ch;
				tok_value   = '0;
			end
			if (digits_only && is_digit(ch)) begin
				wide = 64'(tok_value) * 10 + 64'(ch - "0");
				tok_value = (wide > 64'({VAL_BITS{1'b1}})) ? '1 : VAL_BITS'(wide);
			end else begin
				digits_only = 1'b0;
				tok_value   = '0;
			end
			if (tok_len == 0) begin
				if (!is_letter(ch))
					sym_ok = 1'b0;
			end else if (!is_letter(ch) && !is_digit(ch)) begin
				sym_ok = 1'b0;
			end
			if (tok_len != '1)
				tok_len++;
		end
		if (cur_len != '1)
			cur_len++;
		if (ch == CH_LF)
			bol = 1'b1;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_limit = MAX_SYM_RESET;
			clear_stream();
			expected_tokens.delete();
			records_pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_rec               = '0;
				got_rec.kind          = m_tuser;
				got_rec.line_number   = m_tdata[19:0];
				got_rec.column        = m_tdata[35:20];
				got_rec.token_length  = m_tdata[51:36];
				got_rec.is_number     = m_tdata[52];
				got_rec.number_value  = m_tdata[83:53];
				got_rec.symbol_status = m_tdata[85:84];
				got_rec.address_ok    = m_tdata[86];
				got_rec.first_char    = m_tdata[94:87];
				got_rec.last          = m_tlast;
				if (expected_tokens.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual %h kind %0b",
						$time, m_tdata, m_tuser);
					error_count++;
				end else begin
					want_rec = expected_tokens.pop_front();
					check_field("kind", want_rec.kind, got_rec.kind);
					check_field("line_number", want_rec.line_number, got_rec.line_number);
					check_field("column", want_rec.column, got_rec.column);
					check_field("token_length", want_rec.token_length, got_rec.token_length);
					check_field("is_number", want_rec.is_number, got_rec.is_number);
					check_field("number_value", want_rec.number_value, got_rec.number_value);
					check_field("symbol_status", want_rec.symbol_status, got_rec.symbol_status);
					check_field("address_ok", want_rec.address_ok, got_rec.address_ok);
					check_field("first_char", want_rec.first_char, got_rec.first_char);
					check_field("last", want_rec.last, got_rec.last);
				end
			end
			if (psel && penable && pwrite && pready && paddr == MAX_SYM_LEN_ADDR)
				sym_limit = pwdata[7:0];
			if (s_tvalid && s_tready)
				scan_byte(s_tdata, s_tuser);
			records_pending <= expected_tokens.size();
		end
	end

endmodule

// File: bench/tb_token_scanner_classifier_unit.sv
// ----------------------------------------------------------------------------
// Token scanner / classifier testbench
// Feeds text streams of identifiers, numbers, address letters, junk bytes and
// whitespace under several symbol length limits, with random idling on both
// streams and one long output hold; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_token_scanner_classifier_unit;
	import tsc_pkg::*;

	localparam logic [ADDR_BITS-1:0] MAX_SYM_LEN_ADDR = ADDR_BITS'(4 * REG_MAX_SYM_LEN);
	localparam int IDLE_PCT      = 28;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 4000;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;  // character
	logic                 s_tuser;  // end_of_input
	logic                 m_tvalid;
	logic                 m_tready;
	// line_number, column, token_length, is_number, number_value,
	// symbol_status, address_ok, first_char, zero pad
	logic [95:0]          m_tdata;
	logic                 m_tuser;  // kind
	logic                 m_tlast;
	int                   records_pending;
	int                   error_count;

	logic calm;     // no idling on either side
	logic squeeze;  // ask the receiver for one long hold
	int   quiet_cycles;

	token_scanner_classifier_unit u_top (.*);

	token_record_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [7:0] rand_letter();
		int i;
		i = $urandom_range(51);
		return (i < 26) ? 8'("a" + i) : 8'("A" + i - 26);
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'("0" + $urandom_range(9));
	endfunction

	function automatic logic [7:0] rand_alnum();
		return ($urandom_range(3) == 0) ? rand_digit() : rand_letter();
	endfunction

	function automatic logic [7:0] rand_blank();
		case ($urandom_range(2))
			0: return CH_SPACE;
			1: return CH_TAB;
			default: return CH_LF;
		endcase
	endfunction

	// any byte that is not a delimiter
	function automatic logic [7:0] rand_mark();
		logic [7:0] c;
		do c = 8'($urandom); while (c == CH_SPACE || c == CH_TAB || c == CH_LF);
		return c;
	endfunction

	task automatic send_byte(input logic [7:0] ch, input logic eoi);
		if (!calm) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tuser  <= eoi;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_chars(input string s);
		foreach (s[i])
			send_byte(s[i], 1'b0);
	endtask

	// wait until every record is out and the pipeline has gone quiet
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (records_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_symbol_length(input logic [7:0] value);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= MAX_SYM_LEN_ADDR;
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		pwdata  <= 32'($urandom);
	endtask

	task automatic send_text(input int n_items);
		int    sent;
		int    len;
		int    pick;
		string letters;
		letters = "AIREaQ";
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 4) begin
				send_byte(8'($urandom), 1'b1);
				sent++;
			end else if (pick < 12) begin
				send_byte(8'($urandom), 1'b0);
				sent++;
			end else begin
				case ($urandom_range(9))
					0, 1, 2: begin
						len = $urandom_range(20);
						send_byte(rand_letter(), 1'b0);
						repeat (len) send_byte(rand_alnum(), 1'b0);
						sent += len + 1;
					end
					3, 4: begin
						// long ones run into value saturation
						len = $urandom_range(1, 12);
						repeat (len) send_byte(rand_digit(), 1'b0);
						sent += len;
					end
					5: begin
						send_byte(letters[$urandom_range(5)], 1'b0);
						sent++;
					end
					6: begin
						len = $urandom_range(1, 4);
						repeat (len) send_byte(rand_digit(), 1'b0);
						repeat (len) send_byte(rand_letter(), 1'b0);
						sent += 2 * len;
					end
					7: begin
						len = ($urandom_range(9) == 0) ? $urandom_range(200, 300) :
							$urandom_range(13, 19);
						send_byte(rand_letter(), 1'b0);
						repeat (len - 1) send_byte(rand_alnum(), 1'b0);
						sent += len;
					end
					default: begin
						len = $urandom_range(1, 6);
						if ($urandom_range(1))
							send_byte(rand_letter(), 1'b0);
						else
							send_byte(rand_mark(), 1'b0);
						repeat (len - 1) send_byte(rand_mark(), 1'b0);
						sent += len;
					end
				endcase
				len = $urandom_range(1, 3);
				repeat (len) send_byte(rand_blank(), 1'b0);
				sent += len;
			end
		end
		send_byte(8'($urandom), 1'b1);
	endtask

	initial begin
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (squeeze) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				squeeze = 1'b0;
			end
			m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				quiet_cycles = 0;
			else if (++quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_token_scanner_classifier_unit: FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		calm     = 1'b0;
		squeeze  = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// address letters, every delimiter, odd bytes, value saturation,
		// flush at end of input, then an empty stream
		send_chars("A I\tR\nE ");
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h0D, 1'b0);
		send_chars("\n 4294967296");
		send_byte(8'hA5, 1'b1);
		send_byte(8'h5A, 1'b1);

		write_max_symbol_length(8'd255);
		send_text(300);

		write_max_symbol_length(8'd1);
		calm = 1'b1;
		send_text(250);
		calm = 1'b0;

		// out of range: every token is too long
		write_max_symbol_length(8'd0);
		send_text(150);

		write_max_symbol_length(8'($urandom_range(2, 254)));
		squeeze = 1'b1;
		send_text(300);

		write_max_symbol_length(8'($urandom_range(1, 255)));
		send_text(200);

		drain();
		if (error_count == 0)
			$display("tb_token_scanner_classifier_unit: PASS");
		else
			$display("tb_token_scanner_classifier_unit: FAIL");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/tsc_pkg.sv
rtl/core/tsc_lexer.sv
rtl/core/tsc_result_fifo.sv
rtl/core/token_scanner_classifier_unit.sv
bench/token_record_checker.sv
bench/tb_token_scanner_classifier_unit.sv
